// File: rtl/core/ubxfp_pkg.sv
// Shared types, constants and codes for the UBX frame parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ubxfp_pkg;

	localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
	localparam logic [7:0]  SYNC_SECOND     = 8'h62;
	localparam logic [63:0] CLASS_MASK_RST  = 64'd1657857977974;
	localparam int          QUEUE_DEPTH_DEF = 2;

	// Parser phase codes
	localparam logic [3:0] PH_HUNT    = 4'd0;
	localparam logic [3:0] PH_SYNC2   = 4'd1;
	localparam logic [3:0] PH_CLASS   = 4'd2;
	localparam logic [3:0] PH_ID      = 4'd3;
	localparam logic [3:0] PH_LEN_LO  = 4'd4;
	localparam logic [3:0] PH_LEN_HI  = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CK_A    = 4'd7;
	localparam logic [3:0] PH_CK_B    = 4'd8;

	// Event codes carried on the output tuser
	localparam logic [2:0] EV_FRAMING  = 3'd0;
	localparam logic [2:0] EV_PAYLOAD  = 3'd1;
	localparam logic [2:0] EV_GOOD     = 3'd2;
	localparam logic [2:0] EV_BADSUM   = 3'd3;
	localparam logic [2:0] EV_BADCLASS = 3'd4;
	localparam logic [2:0] EV_GARBAGE  = 3'd5;

	// Received byte with its classification flags
	typedef struct packed {
		logic [7:0] data;
		logic       sync1;
		logic       sync2;
		logic       class_ok;
	} class_word_t;

endpackage

// File: rtl/core/ubx_frame_parser_top.sv
// Top level of the UBX frame parser: front classifier, word queue, back state machine.
// Depends on ubxfp_pkg, ubxfp_front, ubxfp_queue and ubxfp_back.
//
//  channel  | dir | signals                         | contents
//  ---------+-----+---------------------------------+--------------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata[7:0]  | rx_byte
//  m_       | out | m_tvalid m_tready m_tdata[55:0] | payload_byte, payload_index,
//           |     | m_tuser[2:0]                    | msg_class, msg_id, msg_length; event
//  cfg_     | in  | cfg_we cfg_wdata[63:0]          | valid_class_mask
//
// One byte per cycle sustained while m_tready keeps up; each byte's result word passes through
// the front register, a queue entry and the output register before m_tvalid. The back state machine
// settles a byte per cycle while the output register is free or being taken.
// arst_n clears control state and reloads the class mask; no clearing pass is needed.
// A stalled m_tready fills the output register, then the queue, then the front register,
// and only then drops s_tready.
`timescale 1ns / 1ps

module ubx_frame_parser_top #(
	parameter int QUEUE_DEPTH = ubxfp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
	                               // [31:24] msg_class, [39:32] msg_id, [55:40] msg_length
	output logic [2:0]  m_tuser,   // [2:0] event_res
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import ubxfp_pkg::*;

	logic        front_valid;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_not_empty;
	class_word_t front_word;
	class_word_t head_word;

	assign q_push = front_valid && !q_full;

	ubxfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.word_valid (front_valid),
		.word_ready (!q_full),
		.word       (front_word)
	);

	ubxfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (front_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_word (head_word)
	);

	ubxfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (q_not_empty),
		.word_pop   (q_pop),
		.word       (head_word),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_event  (m_tuser),
		.out_data   (m_tdata)
	);

	// A payload word always lies inside the declared length
	a_payload_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_PAYLOAD) |-> (m_tdata[23:8] < m_tdata[55:40]))
		else $error("payload index not below message length");

	// Backpressure reaches the input only once the queue and front register are full
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(front_valid && q_full) |-> !s_tready)
		else $error("input ready while front stage is blocked");

	// The back stage pops only a word that is present
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("pop from empty queue");

	// A full queue with a blocked output stays full
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && m_tvalid && !m_tready) |=> q_full)
		else $error("queue drained while output stalled");

endmodule

// File: rtl/core/ubxfp_front.sv
// Front stage: accepts received bytes, tags sync and class flags, holds the class mask.
// Depends on ubxfp_pkg.
`timescale 1ns / 1ps

module ubxfp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [63:0]            cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_data,
	output logic                   word_valid,
	input  logic                   word_ready,
	output ubxfp_pkg::class_word_t word
);
	import ubxfp_pkg::*;

	logic [63:0] class_mask_q;
	logic        valid_s1;
	class_word_t word_s1;
	class_word_t word_c;

	// Hold the accepted class mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_mask_q <= CLASS_MASK_RST;
		end else if (cfg_we) begin
			class_mask_q <= cfg_wdata;
		end
	end

	// Classify the incoming byte
	always_comb begin
		word_c.data     = in_data;
		word_c.sync1    = (in_data == SYNC_FIRST);
		word_c.sync2    = (in_data == SYNC_SECOND);
		word_c.class_ok = (in_data[7:6] == 2'b00) && class_mask_q[in_data[5:0]];
	end

	assign in_ready = !valid_s1 || word_ready;

	// Advance the stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_c;
		end
	end

	assign word_valid = valid_s1;
	assign word       = word_s1;

endmodule

// File: rtl/core/ubxfp_queue.sv
// Short word queue between the front and back stages.
// Depends on ubxfp_pkg.
`timescale 1ns / 1ps

module ubxfp_queue #(
	parameter int DEPTH = ubxfp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ubxfp_pkg::class_word_t push_word,
	output logic                   full,
	input  logic                   pop,
	output logic                   not_empty,
	output ubxfp_pkg::class_word_t head_word
);
	import ubxfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	class_word_t            entry_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head_word = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// File: rtl/core/ubxfp_back.sv
// Back stage: frame state machine, Fletcher-8 sum and output register.
// Depends on ubxfp_pkg.
`timescale 1ns / 1ps

module ubxfp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   word_valid,
	output logic                   word_pop,
	input  ubxfp_pkg::class_word_t word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             out_event,
	output logic [55:0]            out_data
);
	import ubxfp_pkg::*;

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  ck_a_q, ck_a_d;
	logic [2:0]  ev_d;
	logic [7:0]  pbyte_d;
	logic [15:0] pindex_d;
	logic [7:0]  add_a;
	logic [15:0] cnt_inc;
	logic [3:0]  resync;
	logic        out_valid_q;
	logic [2:0]  out_event_q;
	logic [55:0] out_data_q;

	assign word_pop = word_valid && (!out_valid_q || out_ready);
	assign add_a    = sum_a_q + word.data;
	assign cnt_inc  = cnt_q + 16'd1;
	assign resync   = word.sync1 ? PH_SYNC2 : PH_HUNT;

	// Work out the next state and the event for the head word
	always_comb begin
		phase_d  = phase_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		class_d  = class_q;
		id_d     = id_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		ck_a_d   = ck_a_q;
		ev_d     = EV_FRAMING;
		pbyte_d  = 8'd0;
		pindex_d = 16'd0;
		case (phase_q)
			PH_SYNC2: begin
				if (word.sync2) begin
					phase_d = PH_CLASS;
				end else begin
					ev_d    = EV_GARBAGE;
					phase_d = resync;
				end
			end
			PH_CLASS: begin
				class_d = word.data;
				id_d    = 8'd0;
				len_d   = 16'd0;
				if (word.class_ok) begin
					sum_a_d = word.data;
					sum_b_d = word.data;
					phase_d = PH_ID;
				end else begin
					ev_d    = EV_BADCLASS;
					phase_d = resync;
				end
			end
			PH_ID: begin
				id_d    = word.data;
				sum_a_d = add_a;
				sum_b_d = sum_b_q + add_a;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d   = {8'd0, word.data};
				sum_a_d = add_a;
				sum_b_d = sum_b_q + add_a;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d   = {word.data, len_q[7:0]};
				sum_a_d = add_a;
				sum_b_d = sum_b_q + add_a;
				cnt_d   = 16'd0;
				phase_d = ({word.data, len_q[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				ev_d     = EV_PAYLOAD;
				pbyte_d  = word.data;
				pindex_d = cnt_q;
				sum_a_d  = add_a;
				sum_b_d  = sum_b_q + add_a;
				cnt_d    = cnt_inc;
				if (cnt_inc == len_q) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: begin
				ck_a_d  = word.data;
				phase_d = PH_CK_B;
			end
			PH_CK_B: begin
				if (ck_a_q == sum_a_q && word.data == sum_b_q) begin
					ev_d    = EV_GOOD;
					phase_d = PH_HUNT;
				end else begin
					ev_d = EV_BADSUM;
					if (ck_a_q == SYNC_FIRST && word.sync2) begin
						phase_d = PH_CLASS;
					end else begin
						phase_d = resync;
					end
				end
			end
			default: begin
				if (word.sync1) begin
					phase_d = PH_SYNC2;
				end else begin
					ev_d    = EV_GARBAGE;
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// Update parser state on each popped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_a_q <= '0;
			sum_b_q <= '0;
			class_q <= '0;
			id_q    <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			ck_a_q  <= '0;
		end else if (word_pop) begin
			phase_q <= phase_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			class_q <= class_d;
			id_q    <= id_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			ck_a_q  <= ck_a_d;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (word_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word_pop) begin
			out_event_q <= ev_d;
			out_data_q  <= {len_d, id_d, class_d, pindex_d, pbyte_d};
		end
	end

	assign out_valid = out_valid_q;
	assign out_event = out_event_q;
	assign out_data  = out_data_q;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for ubx_frame_parser_top: streams byte sequences (frames, broken syncs,
// noise) under several class masks and idle patterns and checks every event word it returns.
// Depends on ubxfp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_top;
	import ubxfp_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	// Checksum treatment when building a frame
	localparam int CK_GOOD     = 0;
	localparam int CK_CORRUPT  = 1;
	localparam int CK_SYNCPAIR = 2;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  pbyte;
		logic [15:0] pidx;
		logic [7:0]  cls;
		logic [7:0]  id;
		logic [15:0] len;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;           // [7:0] payload_byte, [23:8] payload_index,
	                                // [31:24] msg_class, [39:32] msg_id, [55:40] msg_length
	logic [2:0]  m_tuser;           // [2:0] event_res
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = 64'd0;

	// Bytes waiting to be sent and event words waiting to come back
	logic [7:0]    rx_pending[$];
	parse_result_t expected_events[$];
	int unsigned   bytes_queued = 0;
	int unsigned   mismatches = 0;
	int unsigned   quiet_cycles = 0;
	int unsigned   src_idle = 0;
	int unsigned   sink_idle = 0;
	bit            resume_at_class = 1'b0;

	// Parser state as the bench sees it
	logic [63:0] class_mask = CLASS_MASK_RST;
	logic [3:0]  ps_phase = PH_HUNT;
	logic [7:0]  acc_a = 8'd0;
	logic [7:0]  acc_b = 8'd0;
	logic [7:0]  cur_class = 8'd0;
	logic [7:0]  cur_id = 8'd0;
	logic [15:0] cur_len = 16'd0;
	logic [15:0] pay_count = 16'd0;
	logic [7:0]  ck_a_seen = 8'd0;

	ubx_frame_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [3:0] sync_phase(logic [7:0] b);
		return (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
	endfunction

	function automatic void fold_sum(logic [7:0] b);
		acc_a = acc_a + b;
		acc_b = acc_b + acc_a;
	endfunction

	// Advance the parser by one byte and return the event word it should emit
	function automatic parse_result_t parse_rx_byte(logic [7:0] b);
		parse_result_t r;
		r = '0;
		r.ev = EV_FRAMING;
		case (ps_phase)
			PH_SYNC2: begin
				if (b == SYNC_SECOND) begin
					ps_phase = PH_CLASS;
				end else begin
					r.ev = EV_GARBAGE;
					ps_phase = sync_phase(b);
				end
			end
			PH_CLASS: begin
				cur_class = b;
				cur_id = 8'd0;
				cur_len = 16'd0;
				if (b < 8'd64 && class_mask[b[5:0]]) begin
					acc_a = 8'd0;
					acc_b = 8'd0;
					fold_sum(b);
					ps_phase = PH_ID;
				end else begin
					r.ev = EV_BADCLASS;
					ps_phase = sync_phase(b);
				end
			end
			PH_ID: begin
				cur_id = b;
				fold_sum(b);
				ps_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				cur_len = {8'd0, b};
				fold_sum(b);
				ps_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				cur_len[15:8] = b;
				fold_sum(b);
				pay_count = 16'd0;
				ps_phase = (cur_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				r.ev = EV_PAYLOAD;
				r.pbyte = b;
				r.pidx = pay_count;
				fold_sum(b);
				pay_count = pay_count + 16'd1;
				if (pay_count == cur_len)
					ps_phase = PH_CK_A;
			end
			PH_CK_A: begin
				ck_a_seen = b;
				ps_phase = PH_CK_B;
			end
			PH_CK_B: begin
				if (ck_a_seen == acc_a && b == acc_b) begin
					r.ev = EV_GOOD;
					ps_phase = PH_HUNT;
				end else begin
					r.ev = EV_BADSUM;
					if (ck_a_seen == SYNC_FIRST && b == SYNC_SECOND)
						ps_phase = PH_CLASS;
					else
						ps_phase = sync_phase(b);
				end
			end
			default: begin
				if (b == SYNC_FIRST) begin
					ps_phase = PH_SYNC2;
				end else begin
					r.ev = EV_GARBAGE;
					ps_phase = PH_HUNT;
				end
			end
		endcase
		r.cls = cur_class;
		r.id = cur_id;
		r.len = cur_len;
		return r;
	endfunction

	function automatic void queue_byte(logic [7:0] b);
		rx_pending.push_back(b);
		bytes_queued++;
	endfunction

	// Pick a class that the current mask accepts (or rejects)
	function automatic logic [7:0] pick_class(bit want_ok);
		logic [7:0] c;
		for (int t = 0; t < 300; t++) begin
			c = want_ok ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 255));
			if ((c < 8'd64 && class_mask[c[5:0]]) == want_ok)
				return c;
		end
		return want_ok ? 8'($urandom_range(0, 63)) : 8'hFF;
	endfunction

	// Queue one frame with random payload; the checksum is right, damaged, or forced to a sync pair
	function automatic void push_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
			int ck_mode, bit with_sync);
		logic [7:0] body[$];
		logic [7:0] ga, gb, ca, cb;
		int unsigned how;
		body = {cls, id, len[7:0], len[15:8]};
		for (int i = 0; i < len; i++)
			body.push_back(8'($urandom_range(0, 255)));
		ga = 8'd0;
		gb = 8'd0;
		foreach (body[i]) begin
			ga = ga + body[i];
			gb = gb + ga;
		end
		ca = ga;
		cb = gb;
		how = $urandom_range(0, 3);
		case (ck_mode)
			CK_CORRUPT: begin
				if (how == 3) begin
					cb = SYNC_FIRST;
				end else begin
					if (how != 1) ca = ca ^ 8'($urandom_range(1, 255));
					if (how != 0) cb = cb ^ 8'($urandom_range(1, 255));
				end
			end
			CK_SYNCPAIR: begin
				ca = SYNC_FIRST;
				cb = SYNC_SECOND;
			end
			default: ;
		endcase
		resume_at_class = (ck_mode == CK_SYNCPAIR) && !(ga == SYNC_FIRST && gb == SYNC_SECOND);
		if (with_sync) begin
			queue_byte(SYNC_FIRST);
			queue_byte(SYNC_SECOND);
		end
		foreach (body[i])
			queue_byte(body[i]);
		queue_byte(ca);
		queue_byte(cb);
	endfunction

	// Mostly well-formed frames, some broken sync or class, some line noise
	task automatic run_random(int unsigned count);
		int unsigned target, kind, pick, ck_mode;
		logic [15:0] len;
		bit with_sync;
		target = bytes_queued + count;
		while (bytes_queued < target) begin
			kind = resume_at_class ? 0 : $urandom_range(0, 99);
			if (kind < 70) begin
				pick = $urandom_range(0, 99);
				if (pick < 1)
					len = 16'(256 + $urandom_range(0, 8));
				else if (pick < 10)
					len = 16'd0;
				else
					len = 16'($urandom_range(1, 12));
				pick = $urandom_range(0, 99);
				ck_mode = (pick < 60) ? CK_GOOD : (pick < 85) ? CK_CORRUPT : CK_SYNCPAIR;
				with_sync = !resume_at_class;
				push_frame(pick_class(1'b1), 8'($urandom_range(0, 255)), len, ck_mode,
					with_sync);
			end else if (kind < 85) begin
				queue_byte(SYNC_FIRST);
				if ($urandom_range(0, 1) == 0) begin
					pick = $urandom_range(0, 255);
					queue_byte((pick == SYNC_SECOND) ? SYNC_FIRST : 8'(pick));
				end else begin
					queue_byte(SYNC_SECOND);
					queue_byte(pick_class(1'b0));
				end
			end else begin
				repeat ($urandom_range(1, 5))
					queue_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Hold until every byte is sent and every event word is back, then let the pipe settle
	task automatic wait_idle();
		while (rx_pending.size() != 0 || s_tvalid || expected_events.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_mask(logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		class_mask = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stimulus sequence
	initial begin
		src_idle = 26;
		sink_idle = 83;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: noise, double first sync, rejected class, empty good frame,
		// rejected class that is itself a first sync, bad sum carrying a sync pair
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(SYNC_FIRST);
		queue_byte(SYNC_FIRST);
		queue_byte(SYNC_SECOND);
		queue_byte(8'h03);
		push_frame(8'h01, 8'h07, 16'd0, CK_GOOD, 1'b1);
		queue_byte(SYNC_FIRST);
		queue_byte(SYNC_SECOND);
		queue_byte(SYNC_FIRST);
		queue_byte(SYNC_SECOND);
		push_frame(8'h28, 8'hFF, 16'd1, CK_SYNCPAIR, 1'b0);
		queue_byte(8'h00);
		resume_at_class = 1'b0;
		wait_idle();

		write_mask({64{1'b1}});
		run_random(230);
		wait_idle();

		src_idle = 83;
		sink_idle = 26;
		write_mask(64'd0);
		run_random(90);
		wait_idle();

		write_mask({$urandom, $urandom});
		run_random(250);
		wait_idle();

		src_idle = 0;
		sink_idle = 0;
		write_mask(64'h8000_0000_0000_0001);
		run_random(130);
		wait_idle();

		write_mask(CLASS_MASK_RST);
		run_random(250);
		wait_idle();

		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Driver: hold a stalled word, otherwise offer the next byte unless idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
		end else begin
			if (s_tvalid && s_tready)
				expected_events.push_back(parse_rx_byte(s_tdata));
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (rx_pending.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
				s_tvalid <= 1'b1;
				s_tdata <= rx_pending.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compare each event word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		parse_result_t want, got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.ev = m_tuser;
				got.pbyte = m_tdata[7:0];
				got.pidx = m_tdata[23:8];
				got.cls = m_tdata[31:24];
				got.id = m_tdata[39:32];
				got.len = m_tdata[55:40];
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected word: ev=%0d byte=%02h idx=%0d cls=%02h id=%02h len=%0d",
							got.ev, got.pbyte, got.pidx, got.cls, got.id, got.len);
				end else begin
					want = expected_events.pop_front();
					if (got.ev !== want.ev || got.pbyte !== want.pbyte || got.pidx !== want.pidx
							|| got.cls !== want.cls || got.id !== want.id
							|| got.len !== want.len) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("mismatch: expected ev=%0d byte=%02h idx=%0d cls=%02h id=%02h len=%0d",
								want.ev, want.pbyte, want.pidx, want.cls, want.id, want.len);
							$display("          got      ev=%0d byte=%02h idx=%0d cls=%02h id=%02h len=%0d",
								got.ev, got.pbyte, got.pidx, got.cls, got.id, got.len);
						end
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= sink_idle);
		end
	end

	// Watchdog: abort when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule
